// File: design/ocf_pkg.sv
`default_nettype none
package ocf_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned ALIGN_BYTES  = 4;
  // padding counts are carried at this width; covers alignments up to 16
  localparam int unsigned PAD_MAX_W    = 4;
  localparam int unsigned Q_DEPTH      = 4;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [7:0]  PAD_BYTE  = 8'hFF;

  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_PART  = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_ORDER = 3'd4;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_FIN,
    CMD_ERR
  } cmd_kind_t;

  // w0: type word / data byte / payload total / error code
  typedef struct packed {
    cmd_kind_t              kind;
    logic [31:0]            w0;
    logic [31:0]            w1;
    logic [31:0]            w2;
    logic [PAD_MAX_W-1:0]   pad;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return ~c;
  endfunction

endpackage
`default_nettype wire

// File: design/ota_container_framer_core.sv
// Path: an input word is written into the command queue; result words are registered onto
// the outputs from the queue head. Throughput: one result word per cycle while out_ready
// is high and a command waits; a begin yields 12 words, a data word 1 plus its padding
// count, finish and errors 1. Input: a word per cycle while the four-entry queue has room.
// Reset: synchronous, active high; clears the CRC, totals, image and error state.
`default_nettype none
module ota_container_framer_core #(
  parameter int unsigned ALIGN_BYTES = ocf_pkg::ALIGN_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] image_kind,
  input  wire logic [31:0] image_length,
  input  wire logic [31:0] start_address,
  input  wire logic [31:0] partition_limit,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             byte_valid,
  output logic [7:0]       out_byte,
  output logic             is_last,
  output logic [2:0]       status,
  output logic [31:0]      container_crc,
  output logic [31:0]      payload_size
);

  ocf_pkg::cmd_t wr_cmd;
  ocf_pkg::cmd_t rd_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;

  ocf_front #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .image_kind     (image_kind),
    .image_length   (image_length),
    .start_address  (start_address),
    .partition_limit(partition_limit),
    .data_byte      (data_byte),
    .q_full         (q_full),
    .push           (push),
    .cmd            (wr_cmd)
  );

  ocf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_cmd  (wr_cmd),
    .full    (q_full),
    .pop     (pop),
    .rd_valid(q_valid),
    .rd_cmd  (rd_cmd)
  );

  ocf_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .cmd          (rd_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .out_byte     (out_byte),
    .is_last      (is_last),
    .status       (status),
    .container_crc(container_crc),
    .payload_size (payload_size)
  );

endmodule
`default_nettype wire

// File: design/ocf_front.sv
`default_nettype none
module ocf_front #(
  parameter int unsigned ALIGN_BYTES = ocf_pkg::ALIGN_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] image_kind,
  input  wire logic [31:0] image_length,
  input  wire logic [31:0] start_address,
  input  wire logic [31:0] partition_limit,
  input  wire logic [7:0]  data_byte,
  input  wire logic        q_full,
  output logic             push,
  output ocf_pkg::cmd_t    cmd
);

  localparam int unsigned RES_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int unsigned SUM_W = RES_W + 2;

  // weight of byte lane i in the residue: 256^i mod ALIGN_BYTES
  function automatic int unsigned lane_weight(input int unsigned i);
    int unsigned r;
    r = 1 % ALIGN_BYTES;
    for (int unsigned k = 0; k < i; k++) begin
      r = (r * 256) % ALIGN_BYTES;
    end
    return r;
  endfunction

  logic [RES_W-1:0] byte_res [4][256];
  logic [RES_W-1:0] sum_mod  [2**SUM_W];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    for (genvar b = 0; b < 256; b++) begin : g_byte
      assign byte_res[i][b] = RES_W'(((b % ALIGN_BYTES) * lane_weight(i)) % ALIGN_BYTES);
    end
  end
  for (genvar s = 0; s < 2**SUM_W; s++) begin : g_mod
    assign sum_mod[s] = RES_W'(s % ALIGN_BYTES);
  end

  logic [31:0]      payload_total;
  logic [31:0]      bytes_left;
  logic [RES_W-1:0] pad_left;
  logic             image_open;
  logic             error_sticky;
  logic [2:0]       err_code;

  logic [31:0]      payload_total_next;
  logic [31:0]      bytes_left_next;
  logic [RES_W-1:0] pad_left_next;
  logic             image_open_next;
  logic             error_sticky_next;
  logic [2:0]       err_code_next;

  logic [SUM_W-1:0] res_sum;
  logic [RES_W-1:0] res;
  logic [RES_W-1:0] pad_calc;
  logic [32:0]      aligned;
  logic [33:0]      total;
  logic             part_err;
  logic             ovf_err;
  logic             last_byte;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign res_sum = SUM_W'(byte_res[0][image_length[7:0]])
                 + SUM_W'(byte_res[1][image_length[15:8]])
                 + SUM_W'(byte_res[2][image_length[23:16]])
                 + SUM_W'(byte_res[3][image_length[31:24]]);

  assign res      = sum_mod[res_sum];
  assign pad_calc = (res == '0) ? '0 : RES_W'(ALIGN_BYTES) - res;
  assign aligned  = {1'b0, image_length} + 33'(pad_calc);
  assign total    = {1'b0, aligned} + 34'(ocf_pkg::HEADER_BYTES);
  assign part_err = aligned > {1'b0, partition_limit};
  assign ovf_err  = total > {2'b00, ~payload_total};
  assign last_byte = bytes_left == 32'd1;

  always_comb begin
    payload_total_next = payload_total;
    bytes_left_next    = bytes_left;
    pad_left_next      = pad_left;
    image_open_next    = image_open;
    error_sticky_next  = error_sticky;
    err_code_next      = err_code;
    cmd.kind = ocf_pkg::CMD_ERR;
    cmd.w0   = '0;
    cmd.w1   = '0;
    cmd.w2   = '0;
    cmd.pad  = '0;

    if (error_sticky) begin
      cmd.w0 = {29'd0, err_code};
    end else begin
      case (func)
        ocf_pkg::FUNC_BEGIN: begin
          if (image_open) begin
            err_code_next = ocf_pkg::ST_ORDER;
          end else if (image_length == '0) begin
            err_code_next = ocf_pkg::ST_ZERO;
          end else if (part_err) begin
            err_code_next = ocf_pkg::ST_PART;
          end else if (ovf_err) begin
            err_code_next = ocf_pkg::ST_OVF;
          end else begin
            cmd.kind = ocf_pkg::CMD_HDR;
            cmd.w0   = image_kind;
            cmd.w1   = aligned[31:0];
            cmd.w2   = start_address;
            payload_total_next = payload_total + total[31:0];
            bytes_left_next    = image_length;
            pad_left_next      = pad_calc;
            image_open_next    = 1'b1;
          end
        end
        ocf_pkg::FUNC_DATA: begin
          if (!image_open || bytes_left == '0) begin
            err_code_next = ocf_pkg::ST_ORDER;
          end else begin
            cmd.kind = ocf_pkg::CMD_DATA;
            cmd.w0   = {24'd0, data_byte};
            cmd.pad  = last_byte ? ocf_pkg::PAD_MAX_W'(pad_left) : '0;
            bytes_left_next = bytes_left - 32'd1;
            if (last_byte) begin
              pad_left_next   = '0;
              image_open_next = 1'b0;
            end
          end
        end
        ocf_pkg::FUNC_FINISH: begin
          if (image_open) begin
            err_code_next = ocf_pkg::ST_ORDER;
          end else begin
            cmd.kind = ocf_pkg::CMD_FIN;
            cmd.w0   = payload_total;
            payload_total_next = '0;
          end
        end
        default: begin
          err_code_next = ocf_pkg::ST_ORDER;
        end
      endcase
      if (cmd.kind == ocf_pkg::CMD_ERR) begin
        error_sticky_next = 1'b1;
        cmd.w0 = {29'd0, err_code_next};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_total <= '0;
      bytes_left    <= '0;
      pad_left      <= '0;
      image_open    <= 1'b0;
      error_sticky  <= 1'b0;
      err_code      <= ocf_pkg::ST_OK;
    end else if (push) begin
      payload_total <= payload_total_next;
      bytes_left    <= bytes_left_next;
      pad_left      <= pad_left_next;
      image_open    <= image_open_next;
      error_sticky  <= error_sticky_next;
      err_code      <= err_code_next;
    end
  end

endmodule
`default_nettype wire

// File: design/ocf_queue.sv
`default_nettype none
module ocf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ocf_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               rd_valid,
  output ocf_pkg::cmd_t      rd_cmd
);

  localparam int unsigned PTR_W = $clog2(ocf_pkg::Q_DEPTH);

  ocf_pkg::cmd_t    entries [ocf_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = count == (PTR_W+1)'(ocf_pkg::Q_DEPTH);
  assign rd_valid = count != '0;
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/ocf_emit.sv
`default_nettype none
module ocf_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire ocf_pkg::cmd_t cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               byte_valid,
  output logic [7:0]         out_byte,
  output logic               is_last,
  output logic [2:0]         status,
  output logic [31:0]        container_crc,
  output logic [31:0]        payload_size
);

  logic [3:0]  cnt;
  logic [31:0] crc_running;
  logic        load;

  logic        g_valid;
  logic [7:0]  g_byte;
  logic        g_last;
  logic [2:0]  g_status;
  logic [31:0] g_crc;
  logic [31:0] g_size;
  logic [31:0] hdr_word;
  logic [1:0]  hdr_lane;

  assign load     = q_valid && (!out_valid || out_ready);
  assign pop      = load && g_last;
  assign hdr_lane = 2'd3 - cnt[1:0];

  always_comb begin
    case (cnt[3:2])
      2'd0:    hdr_word = cmd.w0;
      2'd1:    hdr_word = cmd.w1;
      default: hdr_word = cmd.w2;
    endcase
  end

  always_comb begin
    g_valid  = 1'b0;
    g_byte   = '0;
    g_last   = 1'b1;
    g_status = ocf_pkg::ST_OK;
    g_crc    = '0;
    g_size   = '0;
    case (cmd.kind)
      ocf_pkg::CMD_HDR: begin
        g_valid = 1'b1;
        g_byte  = hdr_word[8*hdr_lane +: 8];
        g_last  = cnt == 4'(ocf_pkg::HEADER_BYTES - 1);
      end
      ocf_pkg::CMD_DATA: begin
        g_valid = 1'b1;
        g_byte  = (cnt == '0) ? cmd.w0[7:0] : ocf_pkg::PAD_BYTE;
        g_last  = cnt == cmd.pad;
      end
      ocf_pkg::CMD_FIN: begin
        g_crc  = crc_running;
        g_size = cmd.w0;
      end
      default: begin
        g_status = cmd.w0[2:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      cnt         <= '0;
      crc_running <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= g_last ? '0 : cnt + 1'b1;
        if (g_valid) begin
          crc_running <= ocf_pkg::crc_byte(crc_running, g_byte);
        end else if (cmd.kind == ocf_pkg::CMD_FIN) begin
          crc_running <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      byte_valid    <= g_valid;
      out_byte      <= g_byte;
      is_last       <= g_last;
      status        <= g_status;
      container_crc <= g_crc;
      payload_size  <= g_size;
    end
  end

endmodule
`default_nettype wire
